// File: hw/rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by the digit cell, the cell chain and the top level.
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  // widths fixed by the character format
  localparam int DIGIT_W = 4;
  localparam int FRAC_W  = 4;
  localparam int CHAR_W  = 6;

  // ascii codes, truncated to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'h30;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 6'h2E;

  // a bcd digit at or above this value is corrected before doubling
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  // control shared by every cell of the chain
  typedef struct packed {
    logic clear;  // zero the digit
    logic shift;  // double the digit and take the bit from below
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii.sv
// Top level: binary value in, decimal ascii characters out, one per transaction.
// Depends on b2da_pkg and b2da_chain (which holds the b2da_cell row).
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_value
//   out_    | output    | out_valid/out_stall | out_character, out_last
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_fraction_digits
//
// A value is loaded, shifted through the cell row one bit per cycle, and its
// digits are counted in ST_FIN; characters then follow at one per cycle
// when the output is not stalled.
// The last character sits in the output register while the next value converts.
// rst_n is synchronous, active low; the digit cells are cleared on each load.
// An output stall holds the character register and pauses emission.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_BITS-1:0]  in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_character,
  output logic                        out_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [FRAC_W-1:0]      cfg_fraction_digits
);

  localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CMP_W = (CNT_W > FRAC_W) ? CNT_W : FRAC_W;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_FIN, ST_EMIT} state_t;

  state_t                       state_r;
  logic [VALUE_BITS-1:0]        sh_r;
  logic [BIT_W-1:0]             bit_cnt_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [IDX_W-1:0]             idx_r;
  logic                         point_r;
  logic [FRAC_W-1:0]            frac_r;
  logic                         out_valid_r;
  logic [CHAR_W-1:0]            out_char_r;
  logic                         out_last_r;

  cell_ctrl_t                   ctrl;
  logic [MAX_DIGITS*DIGIT_W-1:0] digits;
  logic [DIGIT_W-1:0]           next_dig;
  logic [DIGIT_W-1:0]           idx_dig;
  logic                         grow;
  logic                         out_free;
  logic                         few_digits;
  logic                         at_point;
  logic                         in_accept;

  // digit chain
  b2da_chain #(
    .NUM_DIGITS (MAX_DIGITS)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .bit_in (sh_r[VALUE_BITS-1]),
    .digits (digits)
  );

  // handshake and chain control
  always_comb begin
    in_accept  = in_valid && (state_r == ST_IDLE);
    ctrl.clear = in_accept;
    ctrl.shift = (state_r == ST_CONV);
    out_free   = !out_valid_r || !out_stall;
  end

  // digit selection: the cell just above the count, and the one being emitted
  always_comb begin
    next_dig = '0;
    idx_dig  = '0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (CNT_W'(j) == count_r) begin
        next_dig = digits[j*DIGIT_W +: DIGIT_W];
      end
      if (IDX_W'(j) == idx_r) begin
        idx_dig = digits[j*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // significant digit count grows by at most one per doubling
  always_comb begin
    grow       = (count_r < CNT_W'(MAX_DIGITS)) && (next_dig != '0);
    count_nxt  = count_r + CNT_W'(grow);
    few_digits = CMP_W'(count_r) <= CMP_W'(frac_r);
    at_point   = (frac_r != '0) && (CMP_W'(idx_r) == CMP_W'(frac_r));
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      point_r     <= 1'b0;
      frac_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frac_r <= cfg_fraction_digits;
      end
      // output register loads a character or drains on acceptance
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            sh_r      <= in_value;
            bit_cnt_r <= BIT_W'(VALUE_BITS - 1);
            count_r   <= CNT_W'(1);
            state_r   <= ST_CONV;
          end
        end
        ST_CONV: begin
          sh_r    <= sh_r << 1;
          count_r <= count_nxt;
          if (bit_cnt_r == '0) begin
            state_r <= ST_FIN;
          end else begin
            bit_cnt_r <= bit_cnt_r - BIT_W'(1);
          end
        end
        ST_FIN: begin
          count_r <= count_nxt;
          idx_r   <= IDX_W'(count_nxt - CNT_W'(1));
          point_r <= 1'b0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            priority if (point_r) begin
              out_char_r <= ASCII_POINT;
              out_last_r <= 1'b0;
              point_r    <= 1'b0;
            end else if (few_digits) begin
              out_char_r <= ASCII_ZERO;
              out_last_r <= 1'b1;
              state_r    <= ST_IDLE;
            end else begin
              out_char_r <= ASCII_ZERO | CHAR_W'(idx_dig);
              out_last_r <= (idx_r == '0);
              point_r    <= at_point;
              if (idx_r == '0) begin
                state_r <= ST_IDLE;
              end else begin
                idx_r <= idx_r - IDX_W'(1);
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign cfg_ready     = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/b2da_cell.sv
// One bcd digit cell of the double-dabble chain.
// Depends on b2da_pkg for the control struct and digit constants.
`timescale 1ns / 1ps
`default_nettype none

module b2da_cell import b2da_pkg::*; (
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic               bit_in,
  output logic                    carry_out,
  output logic [DIGIT_W-1:0]      digit
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction, then shift left with the neighbor's bit
  always_comb begin
    adj       = (digit_r >= DABBLE_LIMIT) ? digit_r + DABBLE_ADD : digit_r;
    carry_out = adj[DIGIT_W-1];
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

`default_nettype wire

// File: hw/rtl/b2da_chain.sv
// Row of bcd digit cells; bits enter at the least significant cell.
// Depends on b2da_pkg and b2da_cell.
`timescale 1ns / 1ps
`default_nettype none

module b2da_chain import b2da_pkg::*; #(
  parameter int NUM_DIGITS = 10
) (
  input  wire logic                            clk,
  input  wire cell_ctrl_t                      ctrl,
  input  wire logic                            bit_in,
  output logic [NUM_DIGITS*DIGIT_W-1:0]        digits
);

  logic [NUM_DIGITS-1:0] link;

  // carry of each cell feeds the next one up; the top carry is dropped
  for (genvar j = 0; j < NUM_DIGITS; j++) begin : g_cell
    if (j == NUM_DIGITS - 1) begin : g_top
      b2da_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (link[j]),
        .carry_out (),
        .digit     (digits[j*DIGIT_W +: DIGIT_W])
      );
    end else begin : g_mid
      b2da_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (link[j]),
        .carry_out (link[j+1]),
        .digit     (digits[j*DIGIT_W +: DIGIT_W])
      );
    end
  end

  assign link[0] = bit_in;

endmodule

`default_nettype wire
